>>> sv/hspl_pkg.sv
package hspl_pkg;

  localparam logic [1:0] REQ_HASH_WRITE  = 2'd0;
  localparam logic [1:0] REQ_BLOCK_WRITE = 2'd1;
  localparam logic [1:0] REQ_LOOKUP      = 2'd2;
  localparam logic [1:0] REQ_RESERVED    = 2'd3;

  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_FORMAT = 2'd2;

  localparam logic [1:0] REG_HASH_SLOT_COUNT  = 2'd0;
  localparam logic [1:0] REG_BLOCK_SLOT_COUNT = 2'd1;
  localparam logic [1:0] REG_FILE_TOTAL       = 2'd2;

  localparam int COUNT_W = 13;
  localparam logic [31:0] FILE_ID_MAX = 32'h0000_0fff;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [11:0] slot_index;
    logic [31:0] start_hash;
    logic [31:0] check_word_a;
    logic [31:0] check_word_b;
    logic        slot_free;
    logic [31:0] block_reference;
    logic        block_present;
    logic [11:0] map_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  lookup_status;
    logic [11:0] file_id;
  } rsp_t;

  typedef struct packed {
    logic [31:0] check_a;
    logic [31:0] check_b;
    logic        is_free;
    logic [31:0] block_ref;
  } slot_t;

  typedef struct packed {
    logic        exists;
    logic [11:0] map_offset;
  } block_t;

endpackage

>>> sv/hspl_ram.sv
module hspl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/hash_slot_probe_lookup_unit.sv
// hash slot probe lookup unit
//
// request channel (req_valid / req_stall / req): a beat is taken when valid is
// high and stall is low. table write beats (hash slot or block slot) are
// written in the cycle they are taken and give no response; a request type of
// three is dropped. a lookup beat gives exactly one response beat.
// response channel (rsp_valid / rsp_stall / rsp): the response is held in an
// output register until the receiver drops stall; the unit takes no request
// while a lookup is in flight or its response waits.
// lookup sequence: an empty table goes straight to the response register;
// else a bit-serial divider forms start_hash mod slot count, then each probed
// slot is read from the hash slot memory (registered read) and checked, and on
// a match with an in-range block reference the block slot is read and checked.
// the APB port holds the three count registers; pready is always high.
// reset: control state and the count registers clear to zero; table contents are
// undefined until written.
module hash_slot_probe_lookup_unit #(
  parameter int HASH_SLOTS  = 4096,
  parameter int BLOCK_SLOTS = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  hspl_pkg::req_t      req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output hspl_pkg::rsp_t      rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int HA = $clog2(HASH_SLOTS);
  localparam int BA = $clog2(BLOCK_SLOTS);
  localparam int CW = hspl_pkg::COUNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_BREAD = 3'd4;
  localparam logic [2:0] S_BCHK  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]    state, state_next;
  logic [CW-1:0] hash_slot_count, block_slot_count, file_total;
  logic [CW-1:0] n, nb;
  logic [31:0]   dividend, dividend_next;
  logic [4:0]    bit_cnt, bit_cnt_next;
  logic [CW-1:0] rem, rem_next;
  logic [CW:0]   rem_sh;
  logic [HA-1:0] pos, pos_next;
  logic [CW-1:0] probe_cnt, probe_cnt_next;
  logic [31:0]   pos_inc;
  logic [31:0]   key_a, key_a_next, key_b, key_b_next;
  logic [31:0]   ref_q, ref_next;
  logic [31:0]   diff;
  logic          rsp_valid_next;
  hspl_pkg::rsp_t rsp_next;
  logic          accept;

  logic               hash_we;
  logic [HA-1:0]      hash_waddr;
  hspl_pkg::slot_t    hash_wdata, hash_rdata;
  logic               blk_we;
  logic [BA-1:0]      blk_waddr;
  hspl_pkg::block_t   blk_wdata, blk_rdata;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_slot_count  <= '0;
      block_slot_count <= '0;
      file_total       <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        hspl_pkg::REG_HASH_SLOT_COUNT:  hash_slot_count  <= pwdata[CW-1:0];
        hspl_pkg::REG_BLOCK_SLOT_COUNT: block_slot_count <= pwdata[CW-1:0];
        hspl_pkg::REG_FILE_TOTAL:       file_total       <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      hspl_pkg::REG_HASH_SLOT_COUNT:  prdata = 32'(hash_slot_count);
      hspl_pkg::REG_BLOCK_SLOT_COUNT: prdata = 32'(block_slot_count);
      hspl_pkg::REG_FILE_TOTAL:       prdata = 32'(file_total);
      default:                        prdata = '0;
    endcase
  end

  // counts saturate at the table depth
  assign n  = (32'(hash_slot_count) > 32'(HASH_SLOTS)) ? CW'(HASH_SLOTS) : hash_slot_count;
  assign nb = (32'(block_slot_count) > 32'(BLOCK_SLOTS)) ? CW'(BLOCK_SLOTS) :
              block_slot_count;

  // tables
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  assign hash_we    = accept && (req.req_type == hspl_pkg::REQ_HASH_WRITE) &&
                      (32'(req.slot_index) < 32'(HASH_SLOTS));
  assign hash_waddr = HA'(req.slot_index);
  assign hash_wdata = '{check_a: req.check_word_a, check_b: req.check_word_b,
                        is_free: req.slot_free, block_ref: req.block_reference};

  assign blk_we    = accept && (req.req_type == hspl_pkg::REQ_BLOCK_WRITE) &&
                     (32'(req.slot_index) < 32'(BLOCK_SLOTS));
  assign blk_waddr = BA'(req.slot_index);
  assign blk_wdata = '{exists: req.block_present, map_offset: req.map_offset};

  hspl_ram #(
    .WIDTH ($bits(hspl_pkg::slot_t)),
    .DEPTH (HASH_SLOTS)
  ) u_hash_ram (
    .clk   (clk),
    .we    (hash_we),
    .waddr (hash_waddr),
    .wdata (hash_wdata),
    .raddr (pos),
    .rdata (hash_rdata)
  );

  hspl_ram #(
    .WIDTH ($bits(hspl_pkg::block_t)),
    .DEPTH (BLOCK_SLOTS)
  ) u_block_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (blk_waddr),
    .wdata (blk_wdata),
    .raddr (BA'(ref_q)),
    .rdata (blk_rdata)
  );

  // sequencer
  assign rem_sh  = {rem, dividend[31]};
  assign pos_inc = 32'(pos) + 32'd1;
  assign diff    = ref_q - 32'(blk_rdata.map_offset);

  always_comb begin
    state_next     = state;
    dividend_next  = dividend;
    bit_cnt_next   = bit_cnt;
    rem_next       = rem;
    pos_next       = pos;
    probe_cnt_next = probe_cnt;
    key_a_next     = key_a;
    key_b_next     = key_b;
    ref_next       = ref_q;
    rsp_valid_next = rsp_valid;
    rsp_next       = rsp;
    case (state)
      S_IDLE: begin
        if (accept && req.req_type == hspl_pkg::REQ_LOOKUP) begin
          key_a_next    = req.check_word_a;
          key_b_next    = req.check_word_b;
          dividend_next = req.start_hash;
          bit_cnt_next  = 5'd31;
          rem_next      = '0;
          if (n == '0) begin
            rsp_next       = '{lookup_status: hspl_pkg::ST_ABSENT, file_id: '0};
            rsp_valid_next = 1'b1;
            state_next     = S_OUT;
          end else begin
            state_next = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (rem_sh >= {1'b0, n}) begin
          rem_next = CW'(rem_sh - {1'b0, n});
        end else begin
          rem_next = rem_sh[CW-1:0];
        end
        dividend_next = {dividend[30:0], 1'b0};
        bit_cnt_next  = bit_cnt - 5'd1;
        if (bit_cnt == '0) begin
          pos_next       = HA'(rem_next);
          probe_cnt_next = '0;
          state_next     = S_READ;
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (hash_rdata.is_free) begin
          rsp_next       = '{lookup_status: hspl_pkg::ST_ABSENT, file_id: '0};
          rsp_valid_next = 1'b1;
          state_next     = S_OUT;
        end else if (hash_rdata.check_a == key_a && hash_rdata.check_b == key_b) begin
          ref_next = hash_rdata.block_ref;
          if (hash_rdata.block_ref >= 32'(nb)) begin
            rsp_next       = '{lookup_status: hspl_pkg::ST_FORMAT, file_id: '0};
            rsp_valid_next = 1'b1;
            state_next     = S_OUT;
          end else begin
            state_next = S_BREAD;
          end
        end else if (probe_cnt + CW'(1) == n) begin
          rsp_next       = '{lookup_status: hspl_pkg::ST_ABSENT, file_id: '0};
          rsp_valid_next = 1'b1;
          state_next     = S_OUT;
        end else begin
          probe_cnt_next = probe_cnt + CW'(1);
          pos_next       = (pos_inc >= 32'(n)) ? '0 : HA'(pos_inc);
          state_next     = S_READ;
        end
      end
      S_BREAD: begin
        state_next = S_BCHK;
      end
      S_BCHK: begin
        if (!blk_rdata.exists || diff >= 32'(file_total) ||
            diff > hspl_pkg::FILE_ID_MAX) begin
          rsp_next = '{lookup_status: hspl_pkg::ST_FORMAT, file_id: '0};
        end else begin
          rsp_next = '{lookup_status: hspl_pkg::ST_FOUND, file_id: diff[11:0]};
        end
        rsp_valid_next = 1'b1;
        state_next     = S_OUT;
      end
      S_OUT: begin
        if (!rsp_stall) begin
          rsp_valid_next = 1'b0;
          state_next     = S_IDLE;
        end
      end
      default: begin
        rsp_valid_next = 1'b0;
        state_next     = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    dividend  <= dividend_next;
    bit_cnt   <= bit_cnt_next;
    rem       <= rem_next;
    pos       <= pos_next;
    probe_cnt <= probe_cnt_next;
    key_a     <= key_a_next;
    key_b     <= key_b_next;
    ref_q     <= ref_next;
    rsp       <= rsp_next;
  end

  // checks
  a_rem_below_count: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < n)
    else $error("divider remainder not below slot count");

  a_pos_below_count: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> (32'(pos) < 32'(n) && probe_cnt < n))
    else $error("probe position or count out of range");

  a_rsp_blocks_req: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (req_stall && state == S_OUT))
    else $error("request taken while response pending");

  a_number_only_when_found: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.lookup_status != hspl_pkg::ST_FOUND) |-> rsp.file_id == '0)
    else $error("file number set on a failed lookup");

endmodule

>>> verif/hash_slot_probe_lookup_unit_tb.sv
module hash_slot_probe_lookup_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LONG_HOLD = 400;
  localparam longint unsigned CYCLE_LIMIT = 3_000_000;

  typedef struct {
    hspl_pkg::req_t beat;
    bit             has_rsp;
    hspl_pkg::rsp_t rsp;
  } queued_beat_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  hspl_pkg::req_t req_beat = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  hspl_pkg::rsp_t rsp_beat;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [3:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;

  // table image and count registers as the unit should hold them
  hspl_pkg::slot_t  slot_mem [TABLE_DEPTH];
  bit               slot_seen [TABLE_DEPTH];
  hspl_pkg::block_t block_mem [TABLE_DEPTH];
  bit               block_seen [TABLE_DEPTH];
  logic [12:0]      cfg_slots = '0;
  logic [12:0]      cfg_blocks = '0;
  logic [12:0]      cfg_files = '0;

  queued_beat_t   beat_q [$];
  hspl_pkg::rsp_t rsp_due_q [$];
  int unsigned    probe_region [$];
  int unsigned    block_pool [$];

  queued_beat_t    cur_beat;
  int unsigned     gap_left = 0;
  int unsigned     stall_left = 0;
  bit              stall_now = 1'b0;
  bit              no_idling = 1'b0;
  bit              hold_request = 1'b0;
  bit              hold_done = 1'b0;
  longint unsigned cycles = 0;

  int unsigned n_writes = 0;
  int unsigned n_lookups = 0;
  int unsigned n_found = 0;
  int unsigned n_absent = 0;
  int unsigned n_format = 0;
  int unsigned n_settings = 0;
  int unsigned n_checked = 0;
  int unsigned mismatches = 0;

  hash_slot_probe_lookup_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req_beat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp_beat),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5ns clk = ~clk;

  // walks the probe sequence; returns 0 if it would touch an entry never written
  function automatic bit resolve_lookup(input hspl_pkg::req_t r, output hspl_pkg::rsp_t o);
    int unsigned      n;
    int unsigned      nb;
    int unsigned      pos;
    int unsigned      k;
    hspl_pkg::slot_t  s;
    hspl_pkg::block_t b;
    logic [31:0]      diff;
    n = (cfg_slots > TABLE_DEPTH) ? TABLE_DEPTH : cfg_slots;
    nb = (cfg_blocks > TABLE_DEPTH) ? TABLE_DEPTH : cfg_blocks;
    o.lookup_status = hspl_pkg::ST_ABSENT;
    o.file_id = '0;
    if (n == 0) return 1'b1;
    pos = r.start_hash % n;
    for (k = 0; k < n; k++) begin
      if (!slot_seen[pos]) return 1'b0;
      s = slot_mem[pos];
      if (s.is_free) return 1'b1;
      if (s.check_a == r.check_word_a && s.check_b == r.check_word_b) begin
        if (s.block_ref >= nb) begin
          o.lookup_status = hspl_pkg::ST_FORMAT;
          return 1'b1;
        end
        if (!block_seen[s.block_ref]) return 1'b0;
        b = block_mem[s.block_ref];
        if (!b.exists) begin
          o.lookup_status = hspl_pkg::ST_FORMAT;
          return 1'b1;
        end
        diff = s.block_ref - {20'd0, b.map_offset};
        if (diff >= cfg_files || diff > hspl_pkg::FILE_ID_MAX) begin
          o.lookup_status = hspl_pkg::ST_FORMAT;
        end else begin
          o.lookup_status = hspl_pkg::ST_FOUND;
          o.file_id = diff[11:0];
        end
        return 1'b1;
      end
      pos++;
      if (pos >= n) pos = 0;
    end
    return 1'b1;
  endfunction

  // updates the table image and queues the beat with its expected response
  function automatic bit stage_beat(input hspl_pkg::req_t r);
    queued_beat_t   qb;
    hspl_pkg::rsp_t o;
    qb.beat = r;
    qb.has_rsp = 1'b0;
    qb.rsp = '0;
    case (r.req_type)
      hspl_pkg::REQ_HASH_WRITE: begin
        slot_mem[r.slot_index] = {r.check_word_a, r.check_word_b, r.slot_free,
                                  r.block_reference};
        slot_seen[r.slot_index] = 1'b1;
      end
      hspl_pkg::REQ_BLOCK_WRITE: begin
        block_mem[r.slot_index] = {r.block_present, r.map_offset};
        block_seen[r.slot_index] = 1'b1;
      end
      hspl_pkg::REQ_LOOKUP: begin
        if (!resolve_lookup(r, o)) return 1'b0;
        qb.has_rsp = 1'b1;
        qb.rsp = o;
      end
      default: ;
    endcase
    beat_q.push_back(qb);
    return 1'b1;
  endfunction

  function automatic hspl_pkg::req_t rand_beat();
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return hspl_pkg::req_t'(raw[$bits(hspl_pkg::req_t)-1:0]);
  endfunction

  function automatic hspl_pkg::req_t mk_hash(input int unsigned idx, input logic [31:0] a,
                                             input logic [31:0] b, input bit fr,
                                             input logic [31:0] bref);
    hspl_pkg::req_t r;
    r = rand_beat();
    r.req_type = hspl_pkg::REQ_HASH_WRITE;
    r.slot_index = idx[11:0];
    r.check_word_a = a;
    r.check_word_b = b;
    r.slot_free = fr;
    r.block_reference = bref;
    return r;
  endfunction

  function automatic hspl_pkg::req_t mk_block(input int unsigned idx, input bit present,
                                              input logic [11:0] off);
    hspl_pkg::req_t r;
    r = rand_beat();
    r.req_type = hspl_pkg::REQ_BLOCK_WRITE;
    r.slot_index = idx[11:0];
    r.block_present = present;
    r.map_offset = off;
    return r;
  endfunction

  function automatic hspl_pkg::req_t mk_lookup(input logic [31:0] h, input logic [31:0] a,
                                               input logic [31:0] b);
    hspl_pkg::req_t r;
    r = rand_beat();
    r.req_type = hspl_pkg::REQ_LOOKUP;
    r.start_hash = h;
    r.check_word_a = a;
    r.check_word_b = b;
    return r;
  endfunction

  // a full 32-bit start hash that lands on the given slot
  function automatic logic [31:0] hash_for(input int unsigned n, input int unsigned start);
    longint unsigned max_k;
    longint unsigned k;
    longint unsigned h;
    max_k = (64'hFFFF_FFFF - start) / n;
    k = {$urandom, $urandom} % (max_k + 1);
    h = k * n + start;
    return h[31:0];
  endfunction

  function automatic logic [11:0] pick_offset(input int unsigned ref_idx, input int unsigned ft);
    int unsigned r;
    int unsigned span;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      span = (ft == 0) ? 0 : ft - 1;
      if (span > ref_idx) span = ref_idx;
      return 12'(ref_idx - $urandom_range(0, span));
    end
    if (r < 75 && ft <= ref_idx) return 12'(ref_idx - ft);
    return 12'($urandom_range(0, 4095));
  endfunction

  function automatic logic [31:0] pick_ref(input int unsigned nb);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (block_pool.size() > 0 && r < 80)
      return block_pool[$urandom_range(0, block_pool.size() - 1)];
    if (r < 90) return $urandom;
    return nb + $urandom_range(0, 15);
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    if (no_idling) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic wait_idle();
    do @(posedge clk); while (beat_q.size() != 0 || req_valid || rsp_due_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [12:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {19'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_counts(input int unsigned n, input int unsigned nb, input int unsigned ft);
    wait_idle();
    reg_write(hspl_pkg::REG_HASH_SLOT_COUNT, 13'(n));
    cfg_slots = 13'(n);
    reg_write(hspl_pkg::REG_BLOCK_SLOT_COUNT, 13'(nb));
    cfg_blocks = 13'(nb);
    reg_write(hspl_pkg::REG_FILE_TOTAL, 13'(ft));
    cfg_files = 13'(ft);
    n_settings++;
  endtask

  task automatic run_phase(input int unsigned n_raw, input int unsigned nb_raw,
                           input int unsigned ft_raw, input int unsigned count,
                           input int unsigned free_pct);
    int unsigned    n;
    int unsigned    nb;
    int unsigned    base;
    int unsigned    len;
    int unsigned    pos;
    int unsigned    start;
    int unsigned    i;
    int unsigned    made;
    int unsigned    pick;
    logic [31:0]    ka;
    hspl_pkg::req_t r;
    set_counts(n_raw, nb_raw, ft_raw);
    n = (n_raw > TABLE_DEPTH) ? TABLE_DEPTH : n_raw;
    nb = (nb_raw > TABLE_DEPTH) ? TABLE_DEPTH : nb_raw;
    probe_region.delete();
    block_pool.delete();
    if (nb > 0) begin
      len = (nb < 24) ? nb : 24;
      base = $urandom_range(0, nb - len);
      for (i = 0; i < len; i++) begin
        block_pool.push_back(base + i);
        void'(stage_beat(mk_block(base + i, $urandom_range(0, 9) != 0,
                                  pick_offset(base + i, ft_raw))));
      end
    end
    if (n > 0) begin
      if (n <= 64) begin
        base = 0;
        len = n;
      end else begin
        base = $urandom_range(0, n - 1);
        len = $urandom_range(8, 40);
      end
      for (i = 0; i < len; i++) begin
        pos = (base + i) % n;
        probe_region.push_back(pos);
        void'(stage_beat(mk_hash(pos, $urandom, $urandom,
                                 $urandom_range(0, 99) < free_pct, pick_ref(nb))));
      end
      // cluster ends on a free slot so probes stay inside written entries
      if (n > 64) void'(stage_beat(mk_hash((base + len) % n, $urandom, $urandom, 1'b1, $urandom)));
    end
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (n == 0 && pick < 65) pick = 66;
      if (pick < 45) begin
        pos = probe_region[$urandom_range(0, probe_region.size() - 1)];
        start = (pos + n - ($urandom_range(0, 3) % n)) % n;
        r = mk_lookup(hash_for(n, start), slot_mem[pos].check_a, slot_mem[pos].check_b);
      end else if (pick < 65) begin
        pos = probe_region[$urandom_range(0, probe_region.size() - 1)];
        ka = (pick < 52) ? slot_mem[pos].check_a : $urandom;
        r = mk_lookup(hash_for(n, pos), ka, $urandom);
      end else if (pick < 70) begin
        r = mk_lookup($urandom, $urandom, $urandom);
      end else if (pick < 82) begin
        pos = (n > 0) ? probe_region[$urandom_range(0, probe_region.size() - 1)]
                      : $urandom_range(0, 4095);
        r = mk_hash(pos, $urandom, $urandom, $urandom_range(0, 9) == 0, pick_ref(nb));
      end else if (pick < 90) begin
        pos = (block_pool.size() > 0 && pick < 87)
              ? block_pool[$urandom_range(0, block_pool.size() - 1)] : $urandom_range(0, 4095);
        r = mk_block(pos, $urandom_range(0, 9) != 0, pick_offset(pos, ft_raw));
      end else if (pick < 95) begin
        r = rand_beat();
        r.req_type = hspl_pkg::REQ_HASH_WRITE;
      end else begin
        r = rand_beat();
        r.req_type = hspl_pkg::REQ_RESERVED;
        void'(stage_beat(r));
        continue;
      end
      if (stage_beat(r)) made++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (req_valid && !req_stall) begin
        if (cur_beat.beat.req_type == hspl_pkg::REQ_LOOKUP) begin
          n_lookups++;
          if (cur_beat.rsp.lookup_status == hspl_pkg::ST_FOUND) n_found++;
          else if (cur_beat.rsp.lookup_status == hspl_pkg::ST_ABSENT) n_absent++;
          else n_format++;
        end else if (cur_beat.beat.req_type != hspl_pkg::REQ_RESERVED) begin
          n_writes++;
        end
        if (cur_beat.has_rsp) rsp_due_q.push_back(cur_beat.rsp);
      end
      if (!req_valid || !req_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (beat_q.size() > 0) begin
          cur_beat = beat_q.pop_front();
          req_beat <= cur_beat.beat;
          req_valid <= 1'b1;
          gap_left = gap_len();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and receiver stall
  always @(posedge clk) begin
    hspl_pkg::rsp_t due;
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left = 0;
      stall_now = 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        n_checked++;
        if (rsp_due_q.size() == 0) begin
          mismatches++;
          $display("%0t: response beat with none due: status %0d file %0d",
                   $time, rsp_beat.lookup_status, rsp_beat.file_id);
        end else begin
          due = rsp_due_q.pop_front();
          if (rsp_beat.lookup_status !== due.lookup_status) begin
            mismatches++;
            $display("%0t: lookup_status expected %0d actual %0d",
                     $time, due.lookup_status, rsp_beat.lookup_status);
          end
          if (rsp_beat.file_id !== due.file_id) begin
            mismatches++;
            $display("%0t: file_id expected %0d actual %0d",
                     $time, due.file_id, rsp_beat.file_id);
          end
        end
      end
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        stall_now = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (no_idling) begin
        stall_now = 1'b0;
      end else begin
        stall_now = ($urandom_range(0, 2) == 0);
        if (stall_now)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        else
          stall_left = $urandom_range(0, 12);
      end
      rsp_stall <= stall_now;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("hash_slot_probe_lookup_unit verification failed");
      $finish;
    end
  end

  initial begin
    logic [31:0]    k0a;
    logic [31:0]    k0b;
    logic [31:0]    k1a;
    logic [31:0]    k1b;
    logic [31:0]    k2a;
    logic [31:0]    k2b;
    logic [31:0]    k3a;
    logic [31:0]    k3b;
    hspl_pkg::req_t r;
    k0a = $urandom; k0b = $urandom;
    k1a = $urandom; k1b = $urandom;
    k2a = $urandom; k2b = $urandom;
    k3a = $urandom; k3b = $urandom;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty table after reset, then an ignored request type
    r = '0;
    r.req_type = hspl_pkg::REQ_LOOKUP;
    void'(stage_beat(r));
    r = '1;
    r.req_type = hspl_pkg::REQ_LOOKUP;
    void'(stage_beat(r));
    r = rand_beat();
    r.req_type = hspl_pkg::REQ_RESERVED;
    void'(stage_beat(r));

    // four-slot table covering each outcome of a match
    set_counts(4, 4, 3);
    void'(stage_beat(mk_block(0, 1'b1, 12'd0)));
    void'(stage_beat(mk_block(1, 1'b0, 12'($urandom))));
    void'(stage_beat(mk_block(2, 1'b1, 12'hFFF)));
    void'(stage_beat(mk_block(3, 1'b1, 12'd0)));
    void'(stage_beat(mk_block(4095, 1'b1, 12'hFFF)));
    void'(stage_beat(mk_hash(0, k0a, k0b, 1'b0, 32'd0)));
    void'(stage_beat(mk_hash(1, k1a, k1b, 1'b0, 32'd1)));
    void'(stage_beat(mk_hash(2, k2a, k2b, 1'b0, 32'd2)));
    void'(stage_beat(mk_hash(3, k3a, k3b, 1'b0, 32'hFFFF_FFFF)));
    void'(stage_beat(mk_hash(4095, '1, '1, 1'b1, '1)));
    void'(stage_beat(mk_lookup(32'd0, k0a, k0b)));
    void'(stage_beat(mk_lookup(32'd1, k1a, k1b)));
    void'(stage_beat(mk_lookup(32'hFFFF_FFFE, k2a, k2b)));
    void'(stage_beat(mk_lookup(32'd3, k3a, k3b)));
    void'(stage_beat(mk_lookup(32'hFFFF_FFFF, k0a, k0b)));
    void'(stage_beat(mk_lookup(32'd2, ~k0a, ~k0b)));
    void'(stage_beat(mk_lookup(32'd0, k0a, ~k0b)));
    void'(stage_beat(mk_hash(2, k2a, k2b, 1'b0, 32'd3)));
    void'(stage_beat(mk_lookup(32'd2, k2a, k2b)));
    void'(stage_beat(mk_hash(1, k1a, k1b, 1'b1, 32'd1)));
    void'(stage_beat(mk_lookup(32'd0, ~k0a, k0b)));

    run_phase(16, 16, 16, 60, 15);
    run_phase(16, 16, 16, 30, 0);
    hold_request = 1'b1;
    run_phase(8191, 8191, 8191, 60, 5);
    no_idling = 1'b1;
    run_phase(4096, 4096, 4096, 50, 5);
    no_idling = 1'b0;
    run_phase(3001, 4096, 4095, 50, 5);
    run_phase(1, 4, 2, 30, 20);
    run_phase(40, 0, 16, 30, 10);
    run_phase(64, 300, 0, 30, 10);
    run_phase(0, 0, 0, 20, 0);
    run_phase(33, 2048, 100, 60, 10);
    run_phase(4096, 16, 4096, 40, 5);
    run_phase(7, 4096, 1, 40, 15);

    wait_idle();
    $display("run covered %0d table writes and %0d lookups (%0d found, %0d absent, %0d format)",
             n_writes, n_lookups, n_found, n_absent, n_format);
    $display("over %0d count settings; %0d response beats checked, %0d mismatches",
             n_settings, n_checked, mismatches);
    if (mismatches == 0) begin
      $display("hash_slot_probe_lookup_unit verification clean");
    end else begin
      $display("hash_slot_probe_lookup_unit verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/hspl_pkg.sv
sv/hspl_ram.sv
sv/hash_slot_probe_lookup_unit.sv
verif/hash_slot_probe_lookup_unit_tb.sv
